### rtl/stri_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stri_pkg: shared types and codes for the sorted table
// Request codes, status codes, field widths and the cell control bundle.
// ----------------------------------------------------------------------------
package stri_pkg;

    localparam int CAPACITY_DEF = 16;

    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 4;
    localparam int COUNT_W  = 5;
    localparam int LIMIT_W  = 5;
    localparam int ACTION_W = 2;
    localparam int STATUS_W = 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Broadcast to every cell in the row for one beat.
    typedef struct packed {
        logic               do_ins;
        logic               do_rem;
        logic [VALUE_W-1:0] value;
    } t_cell_ctrl;

endpackage

### rtl/stri_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stri_cell: one slot of the sorted row
// Holds one entry; compares it with the insert value and shifts up or down.
// ----------------------------------------------------------------------------
module stri_cell (
    input  logic                          i_clk,
    input  stri_pkg::t_cell_ctrl          i_ctrl,
    input  logic                          i_in_use,
    input  logic                          i_shift_down,
    input  logic                          i_left_lt,
    input  logic [stri_pkg::VALUE_W-1:0]  i_left_entry,
    input  logic [stri_pkg::VALUE_W-1:0]  i_right_entry,
    output logic                          o_lt,
    output logic [stri_pkg::VALUE_W-1:0]  o_entry
);

    logic [stri_pkg::VALUE_W-1:0] r_entry;
    logic [stri_pkg::VALUE_W-1:0] n_entry;

    // Entry is below the insert value: the new value lands above this slot.
    assign o_lt    = i_in_use && (r_entry < i_ctrl.value);
    assign o_entry = r_entry;

    always_comb begin
        n_entry = r_entry;
        if (i_ctrl.do_ins && !o_lt) begin
            // first slot not below the value takes it, the rest move up
            n_entry = i_left_lt ? i_ctrl.value : i_left_entry;
        end else if (i_ctrl.do_rem && i_shift_down) begin
            n_entry = i_right_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

endmodule

### rtl/sorted_table_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_insert_remove_core: ascending table of 32-bit values
// Insert, lookup by index and remove by index over a row of shift cells.
// ----------------------------------------------------------------------------
// Usage
//   Request channel: drive i_action, i_value, i_index with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   busy stays low, so one request is taken in every cycle.
//   Result channel: o_done pulses for one cycle, in the cycle after the request
//   edge, with o_read_value, o_count and o_status. The receiver cannot
//   stall; each result is on the ports for that one cycle only.
//   Throughput is 1 request per cycle: every cell in the row compares its
//   entry with the insert value in parallel and loads its own value, its
//   left neighbor, the new value or its right neighbor at the same edge, so
//   an insert or a remove finishes in a single step.
//   Configuration: i_cfg_we with i_cfg_wdata writes the capacity limit
//   (reset 16, saturated at CAPACITY); write it only while idle.
//   Reset (i_rst_n low, synchronous) empties the table and restores the
//   limit. Entry storage is not cleared; only slots below the count are read.
// ----------------------------------------------------------------------------
module sorted_table_insert_remove_core #(
    parameter int CAPACITY = stri_pkg::CAPACITY_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [stri_pkg::ACTION_W-1:0]  i_action,
    input  logic [stri_pkg::VALUE_W-1:0]   i_value,
    input  logic [stri_pkg::INDEX_W-1:0]   i_index,
    input  logic                           i_cfg_we,
    input  logic [stri_pkg::LIMIT_W-1:0]   i_cfg_wdata,
    output logic                           o_done,
    output logic [stri_pkg::VALUE_W-1:0]   o_read_value,
    output logic [stri_pkg::COUNT_W-1:0]   o_count,
    output logic [stri_pkg::STATUS_W-1:0]  o_status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    // common width for count / limit / index compares
    localparam int XW0  = (CW > stri_pkg::LIMIT_W) ? CW : stri_pkg::LIMIT_W;
    localparam int XW   = (XW0 > stri_pkg::INDEX_W) ? XW0 : stri_pkg::INDEX_W;
    // only the first slots are reachable through the index field
    localparam int LOOK = (CAPACITY < (1 << stri_pkg::INDEX_W)) ?
                          CAPACITY : (1 << stri_pkg::INDEX_W);
    localparam logic [XW-1:0] CAP_X = XW'(CAPACITY);

    logic                          r_done;
    logic [stri_pkg::VALUE_W-1:0]  r_read_value;
    logic [stri_pkg::STATUS_W-1:0] r_status;
    logic [CW-1:0]                 r_count;
    logic [stri_pkg::LIMIT_W-1:0]  r_limit;

    logic                          n_done;
    logic [stri_pkg::VALUE_W-1:0]  n_read_value;
    logic [stri_pkg::STATUS_W-1:0] n_status;
    logic [CW-1:0]                 n_count;

    logic                          accept;
    logic [XW-1:0]                 count_x;
    logic [XW-1:0]                 limit_x;
    logic [XW-1:0]                 index_x;
    logic                          full;
    logic                          idx_ok;
    logic [stri_pkg::VALUE_W-1:0]  lookup_data;
    stri_pkg::t_cell_ctrl          ctrl;

    logic [CAPACITY-1:0]           cell_lt;
    logic [stri_pkg::VALUE_W-1:0]  cell_entry [CAPACITY];

    // Never hold off requests: every one finishes in the cycle it is taken.
    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign count_x = XW'(r_count);
    assign limit_x = XW'(r_limit);
    assign index_x = XW'(i_index);

    // Full at the register limit, or at the physical row length.
    assign full   = (count_x >= limit_x) || (count_x >= CAP_X);
    assign idx_ok = index_x < count_x;

    assign ctrl.do_ins = accept && (i_action == stri_pkg::ACT_INSERT) && !full;
    assign ctrl.do_rem = accept && (i_action == stri_pkg::ACT_REMOVE) && idx_ok;
    assign ctrl.value  = i_value;

    // Read port over the slots that an index can name.
    always_comb begin
        lookup_data = '0;
        for (int j = 0; j < LOOK; j++) begin
            if (i_index == stri_pkg::INDEX_W'(j)) begin
                lookup_data = cell_entry[j];
            end
        end
    end

    // Row of cells; slot 0 holds the smallest entry.
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic                         left_lt;
        logic [stri_pkg::VALUE_W-1:0] left_entry;
        logic [stri_pkg::VALUE_W-1:0] right_entry;

        if (k == 0) begin : g_first
            assign left_lt    = 1'b1;
            assign left_entry = i_value;
        end else begin : g_mid
            assign left_lt    = cell_lt[k-1];
            assign left_entry = cell_entry[k-1];
        end

        if (k == CAPACITY - 1) begin : g_last
            assign right_entry = cell_entry[k];
        end else begin : g_inner
            assign right_entry = cell_entry[k+1];
        end

        stri_cell u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (ctrl),
            .i_in_use      (k < int'(r_count)),
            .i_shift_down  (k >= int'(i_index)),
            .i_left_lt     (left_lt),
            .i_left_entry  (left_entry),
            .i_right_entry (right_entry),
            .o_lt          (cell_lt[k]),
            .o_entry       (cell_entry[k])
        );
    end

    // Result and count for this beat.
    always_comb begin
        n_done       = accept;
        n_read_value = '0;
        n_status     = stri_pkg::ST_OK;
        n_count      = r_count;
        if (accept) begin
            unique case (i_action)
                stri_pkg::ACT_INSERT: begin
                    if (full) begin
                        n_status = stri_pkg::ST_FULL;
                    end else begin
                        n_count = r_count + CW'(1);
                    end
                end
                stri_pkg::ACT_LOOKUP: begin
                    if (idx_ok) begin
                        n_read_value = lookup_data;
                    end else begin
                        n_status = stri_pkg::ST_RANGE;
                    end
                end
                stri_pkg::ACT_REMOVE: begin
                    if (idx_ok) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = stri_pkg::ST_RANGE;
                    end
                end
                default: begin
                    // unused code: drop the request, report ok
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b0;
            r_count <= '0;
            r_limit <= stri_pkg::LIMIT_RESET;
        end else begin
            r_done  <= n_done;
            r_count <= n_count;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_read_value <= n_read_value;
        r_status     <= n_status;
    end

    logic [XW-1:0] count_out;
    assign count_out    = XW'(r_count);
    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_status     = r_status;
    assign o_count      = count_out[stri_pkg::COUNT_W-1:0];

endmodule

### rtl/stri_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stri_checker: port-level checks for the sorted table
// Watches request and result beats and the reported count over time.
// ----------------------------------------------------------------------------
module stri_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           start,
    input logic                           busy,
    input logic [stri_pkg::ACTION_W-1:0]  i_action,
    input logic                           o_done,
    input logic [stri_pkg::VALUE_W-1:0]   o_read_value,
    input logic [stri_pkg::COUNT_W-1:0]   o_count,
    input logic [stri_pkg::STATUS_W-1:0]  o_status
);

    // one result for each request, in the cycle after it
    a_done_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> o_done)
        else $error("request beat without a result");

    a_no_extra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |=> !o_done)
        else $error("result without a request");

    // count holds between results
    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_done |-> $stable(o_count))
        else $error("count moved without a result");

    // lookup never changes the count
    a_lookup_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && i_action == stri_pkg::ACT_LOOKUP) ##1 o_done
        |-> o_count == $past(o_count))
        else $error("lookup changed the count");

    // failed requests read back zero
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_status != stri_pkg::ST_OK) |-> o_read_value == '0)
        else $error("nonzero read value on a failed request");

endmodule

bind sorted_table_insert_remove_core stri_checker u_stri_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .busy         (busy),
    .i_action     (i_action),
    .o_done       (o_done),
    .o_read_value (o_read_value),
    .o_count      (o_count),
    .o_status     (o_status)
);

### test/tb_sorted_table_insert_remove_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_table_insert_remove_core: self-checking bench for the sorted table
// Drives insert, lookup, remove and ignored requests with random gaps. It
// rewrites the capacity limit between phases and predicts every result beat
// with an in-bench model of the table, checking each field as it arrives.
// ----------------------------------------------------------------------------
module tb_sorted_table_insert_remove_core;

    // Request code that the block must ignore (no change, status ok).
    localparam logic [stri_pkg::ACTION_W-1:0] ACT_IGNORED = 2'd3;

    localparam int CLK_HALF = 6;
    localparam int SLOT_W   = $clog2(stri_pkg::CAPACITY_DEF);

    // One expected result beat.
    typedef struct {
        logic [stri_pkg::VALUE_W-1:0]  read_value;
        logic [stri_pkg::COUNT_W-1:0]  count;
        logic [stri_pkg::STATUS_W-1:0] status;
    } t_table_result;

    // ------------------------------------------------------------------------
    // Table predictor and result store: mirrors the sorted table, queues the
    // result each accepted request should produce, and checks result beats
    // against the oldest queued one.
    // ------------------------------------------------------------------------
    class t_table_scoreboard;
        logic [stri_pkg::VALUE_W-1:0] slots [stri_pkg::CAPACITY_DEF];
        int unsigned                  fill;
        logic [stri_pkg::LIMIT_W-1:0] cap_reg;
        t_table_result                awaiting [$];
        int unsigned                  mismatches;

        function void clear();
            fill    = 0;
            cap_reg = stri_pkg::LIMIT_RESET;
            awaiting.delete();
        endfunction

        function void set_limit(logic [stri_pkg::LIMIT_W-1:0] v);
            cap_reg = v;
        endfunction

        // Apply one accepted request to the table and queue its result.
        function void note_request(logic [stri_pkg::ACTION_W-1:0] act,
                                   logic [stri_pkg::VALUE_W-1:0] value,
                                   logic [stri_pkg::INDEX_W-1:0] idx);
            t_table_result res;
            int unsigned   lim;
            int unsigned   pos;
            int unsigned   k;
            res.read_value = '0;
            res.status     = stri_pkg::ST_OK;
            lim = (cap_reg > stri_pkg::LIMIT_W'(stri_pkg::CAPACITY_DEF)) ?
                  stri_pkg::CAPACITY_DEF : 32'(cap_reg);
            case (act)
                stri_pkg::ACT_INSERT: begin
                    if (fill >= lim) begin
                        res.status = stri_pkg::ST_FULL;
                    end else begin
                        // Land before the first entry that is not less than value.
                        pos = 0;
                        while (pos < fill && slots[pos[SLOT_W-1:0]] < value) pos++;
                        for (k = fill; k > pos; k--) begin
                            slots[k[SLOT_W-1:0]] = slots[k[SLOT_W-1:0] - 1'b1];
                        end
                        slots[pos[SLOT_W-1:0]] = value;
                        fill++;
                    end
                end
                stri_pkg::ACT_LOOKUP: begin
                    if (32'(idx) < fill) res.read_value = slots[idx];
                    else res.status = stri_pkg::ST_RANGE;
                end
                stri_pkg::ACT_REMOVE: begin
                    if (32'(idx) >= fill) begin
                        res.status = stri_pkg::ST_RANGE;
                    end else begin
                        for (k = 32'(idx); k + 1 < fill; k++) begin
                            slots[k[SLOT_W-1:0]] = slots[k[SLOT_W-1:0] + 1'b1];
                        end
                        fill--;
                    end
                end
                default: ;
            endcase
            res.count = fill[stri_pkg::COUNT_W-1:0];
            awaiting.push_back(res);
        endfunction

        function void check_result(logic [stri_pkg::VALUE_W-1:0] rd,
                                   logic [stri_pkg::COUNT_W-1:0] cnt,
                                   logic [stri_pkg::STATUS_W-1:0] st);
            t_table_result exp_res;
            if (awaiting.size() == 0) begin
                $error("result beat with nothing expected: read_value %0h count %0d status %0d",
                       rd, cnt, st);
                mismatches++;
                return;
            end
            exp_res = awaiting.pop_front();
            if (rd !== exp_res.read_value) begin
                $error("read_value: expected %0h, got %0h", exp_res.read_value, rd);
                mismatches++;
            end
            if (cnt !== exp_res.count) begin
                $error("count: expected %0d, got %0d", exp_res.count, cnt);
                mismatches++;
            end
            if (st !== exp_res.status) begin
                $error("status: expected %0d, got %0d", exp_res.status, st);
                mismatches++;
            end
        endfunction
    endclass

    logic                          i_clk;
    logic                          i_rst_n;
    logic                          start;
    logic                          busy;
    logic [stri_pkg::ACTION_W-1:0] i_action;
    logic [stri_pkg::VALUE_W-1:0]  i_value;
    logic [stri_pkg::INDEX_W-1:0]  i_index;
    logic                          i_cfg_we;
    logic [stri_pkg::LIMIT_W-1:0]  i_cfg_wdata;
    logic                          o_done;
    logic [stri_pkg::VALUE_W-1:0]  o_read_value;
    logic [stri_pkg::COUNT_W-1:0]  o_count;
    logic [stri_pkg::STATUS_W-1:0] o_status;

    t_table_scoreboard sb;

    sorted_table_insert_remove_core #(
        .CAPACITY (stri_pkg::CAPACITY_DEF)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_value      (i_value),
        .i_index      (i_index),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .o_done       (o_done),
        .o_read_value (o_read_value),
        .o_count      (o_count),
        .o_status     (o_status)
    );

    initial i_clk = 1'b0;
    always #(CLK_HALF) i_clk = ~i_clk;

    // Result monitor: the strobe and fields are sampled as they stood just
    // before the edge, so the block's own updates at this edge do not race.
    always @(posedge i_clk) begin
        if (o_done === 1'b1) sb.check_result(o_read_value, o_count, o_status);
    end

    // Hold start low for the gap (if any), then present one request beat
    // and wait for the edge that takes it. Start is left high on return so a
    // following zero-gap request goes out back to back without a glitch.
    task automatic send_request(input logic [stri_pkg::ACTION_W-1:0] act,
                                input logic [stri_pkg::VALUE_W-1:0] value,
                                input logic [stri_pkg::INDEX_W-1:0] idx, input int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start    <= 1'b1;
        i_action <= act;
        i_value  <= value;
        i_index  <= idx;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        sb.note_request(act, value, idx);
    endtask

    // Drop start and wait until every expected result beat has come back.
    task automatic hold_until_drained();
        start <= 1'b0;
        while (sb.awaiting.size() != 0) @(posedge i_clk);
    endtask

    // Rewrite the capacity limit while idle. Every request returns a beat,
    // so an empty store means the block is idle; still allow a short margin.
    task automatic write_limit(input logic [stri_pkg::LIMIT_W-1:0] v);
        hold_until_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_limit(v);
    endtask

    // One random phase. ins_pct sets how often an insert is drawn, which
    // steers the table toward full or toward empty; burst removes all gaps.
    task automatic run_phase(input int n_items, input int ins_pct, input bit burst);
        logic [stri_pkg::ACTION_W-1:0] act;
        logic [stri_pkg::VALUE_W-1:0]  value;
        logic [stri_pkg::INDEX_W-1:0]  idx;
        int                            roll;
        int                            gap;
        for (int i = 0; i < n_items; i++) begin
            // Pause once per phase until the table has answered everything.
            if (i == n_items / 2) hold_until_drained();

            roll = $urandom_range(0, 99);
            if (roll < ins_pct) begin
                act = stri_pkg::ACT_INSERT;
            end else begin
                roll = $urandom_range(0, 19);
                if (roll == 0) act = ACT_IGNORED;
                else if (roll < 10) act = stri_pkg::ACT_LOOKUP;
                else act = stri_pkg::ACT_REMOVE;
            end

            // Mix wide values with a narrow band so duplicates show up often.
            roll = $urandom_range(0, 9);
            if (roll < 5) value = $urandom;
            else if (roll < 8) value = $urandom_range(0, 7);
            else case ($urandom_range(0, 3))
                0: value = 32'h0000_0000;
                1: value = 32'hFFFF_FFFF;
                2: value = 32'h8000_0000;
                default: value = 32'h7FFF_FFFF;
            endcase

            // Mostly aim at stored slots; sometimes past the end.
            if (sb.fill > 0 && $urandom_range(0, 5) != 0) begin
                idx = stri_pkg::INDEX_W'($urandom_range(0, sb.fill - 1));
            end else begin
                idx = stri_pkg::INDEX_W'($urandom_range(0, 15));
            end

            gap = burst ? 0 : $urandom_range(0, 14);
            send_request(act, value, idx, gap);
        end
    endtask

    // Watchdog: well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        sb = new();
        sb.mismatches = 0;
        sb.clear();
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_action    <= stri_pkg::ACT_INSERT;
        i_value     <= '0;
        i_index     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty table, ignored request, extremes and duplicates.
        send_request(stri_pkg::ACT_LOOKUP, 32'h0, 4'd0, 0);
        send_request(stri_pkg::ACT_REMOVE, 32'h0, 4'd15, 0);
        send_request(ACT_IGNORED, 32'hFFFF_FFFF, 4'd15, 1);
        send_request(stri_pkg::ACT_INSERT, 32'hFFFF_FFFF, 4'd0, 0);
        send_request(stri_pkg::ACT_INSERT, 32'h0000_0000, 4'd0, 0);
        send_request(stri_pkg::ACT_INSERT, 32'h8000_0000, 4'd0, 2);
        send_request(stri_pkg::ACT_INSERT, 32'h8000_0000, 4'd15, 0);
        send_request(stri_pkg::ACT_INSERT, 32'h0000_0001, 4'd0, 0);
        for (int k = 0; k < 6; k++) begin
            send_request(stri_pkg::ACT_LOOKUP, 32'hFFFF_FFFF, k[stri_pkg::INDEX_W-1:0], 0);
        end
        send_request(stri_pkg::ACT_LOOKUP, 32'h0, 4'd15, 3);
        // Remove from the middle, the bottom, then the top slot.
        send_request(stri_pkg::ACT_REMOVE, 32'h0, 4'd2, 0);
        send_request(stri_pkg::ACT_REMOVE, 32'h0, 4'd0, 0);
        send_request(stri_pkg::ACT_REMOVE, 32'h0, 4'd2, 0);
        send_request(stri_pkg::ACT_LOOKUP, 32'h0, 4'd1, 0);
        send_request(ACT_IGNORED, 32'h0, 4'd0, 0);

        // Limit at the current count: an insert is refused as full, then taken after a remove.
        write_limit(5'd2);
        send_request(stri_pkg::ACT_INSERT, 32'h0000_0005, 4'd0, 0);
        send_request(stri_pkg::ACT_LOOKUP, 32'h0, 4'd0, 0);
        send_request(stri_pkg::ACT_REMOVE, 32'h0, 4'd0, 0);
        send_request(stri_pkg::ACT_INSERT, 32'h0000_0005, 4'd0, 0);

        // Random phases across several limits, the extremes among them.
        write_limit(stri_pkg::LIMIT_RESET);
        run_phase(70, 70, 1'b0);
        write_limit(5'd31);            // saturates at the table capacity
        run_phase(60, 55, 1'b1);
        write_limit(5'd1);             // lowered to a single slot
        run_phase(40, 50, 1'b0);
        write_limit(5'd0);             // every insert refused
        run_phase(30, 50, 1'b0);
        write_limit(stri_pkg::LIMIT_W'($urandom_range(2, 15)));
        run_phase(60, 60, 1'b0);
        write_limit(5'd16);
        run_phase(60, 80, 1'b1);
        write_limit(5'd3);
        run_phase(60, 40, 1'b0);
        write_limit(stri_pkg::LIMIT_W'($urandom_range(0, 31)));
        run_phase(60, 50, 1'b0);

        // Drain, then allow for the block's registered result and a margin.
        hold_until_drained();
        repeat (4) @(posedge i_clk);

        if (sb.mismatches == 0 && sb.awaiting.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
